[hw/rtl/mzss_pkg.sv]
package mzss_pkg;

    localparam int SIZE_W     = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 3;
    localparam int FPTR_W     = 2;

    typedef logic [SIZE_W-1:0]    t_size;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [FPTR_W-1:0]    t_fptr;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_COUNT = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_size square_here;
        t_size largest;
        logic  frame_done;
    } t_result;

endpackage

[hw/rtl/mzss_ram.sv]
module mzss_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/max_zero_square_scan.sv]
// Channel   Handshake             Payload
// cfg       i_cfg_we              i_cfg_idx, i_cfg_data (write only)
// in        i_valid / o_ready     i_cell_req
// out       o_valid / i_ready     o_square_here, o_largest, o_frame_done
//
// One cell per clock sustained while o_ready stays high. o_valid rises once an
// accepted cell has passed the accept-stage register into the output queue.
// Row buffer RAM has registered read: read at accept, size computed and
// written back next cycle, bypassed when back-to-back cells share a column.
// A three-entry output queue absorbs result stalls; o_ready drops when three
// items are queued or in flight. Reset is synchronous, active low.
module max_zero_square_scan #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mzss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mzss_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cell_req,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [mzss_pkg::SIZE_W-1:0]          o_square_here,
    output logic [mzss_pkg::SIZE_W-1:0]          o_largest,
    output logic                                 o_frame_done
);

    localparam int CW   = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
    localparam int RW   = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CEW  = (CCW > mzss_pkg::CFG_W) ? CCW : mzss_pkg::CFG_W;
    localparam int REW  = (RCW > mzss_pkg::CFG_W) ? RCW : mzss_pkg::CFG_W;
    localparam logic [CEW-1:0] COLS_MAX = CEW'(MAX_COLS);
    localparam logic [REW-1:0] ROWS_MAX = REW'(MAX_ROWS);

    typedef struct packed {
        logic [CW-1:0] col;
        logic          blocked;
        logic          top;
        logic          first;
        logic          last;
        logic          fwd;
    } t_stage;

    // configuration
    mzss_pkg::t_cfg_data r_col_count;
    mzss_pkg::t_cfg_data r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= mzss_pkg::CFG_W'(1024);
            r_row_count <= mzss_pkg::CFG_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mzss_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                mzss_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CEW-1:0] cols_ext;
    logic [REW-1:0] rows_ext;
    logic [CEW-1:0] cols_eff;
    logic [REW-1:0] rows_eff;

    always_comb begin
        cols_ext = CEW'(r_col_count);
        rows_ext = REW'(r_row_count);
        if (cols_ext == '0) begin
            cols_eff = CEW'(1);
        end else if (cols_ext > COLS_MAX) begin
            cols_eff = COLS_MAX;
        end else begin
            cols_eff = cols_ext;
        end
        if (rows_ext == '0) begin
            rows_eff = REW'(1);
        end else if (rows_ext > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = rows_ext;
        end
    end

    // accept stage
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_s1_valid;
    t_stage        r_s1;
    logic          in_acc;
    logic          last_col;
    logic          last_row;
    logic [2:0]    fill;
    logic [mzss_pkg::FPTR_W-1:0] r_occ;

    assign fill     = 3'(r_occ) + 3'(r_s1_valid);
    assign o_ready  = (fill < 3'(mzss_pkg::FIFO_DEPTH));
    assign in_acc   = i_valid && o_ready;
    assign last_col = ((CEW'(r_col) + CEW'(1)) >= cols_eff);
    assign last_row = ((REW'(r_row) + REW'(1)) >= rows_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                if (last_col && last_row) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.col     <= r_col;
            r_s1.blocked <= i_cell_req;
            r_s1.top     <= (r_row == '0);
            r_s1.first   <= (r_col == '0);
            r_s1.last    <= last_col && last_row;
            // the cell in flight writes this column at the same edge
            r_s1.fwd     <= r_s1_valid && (r_s1.col == r_col);
        end
    end

    // row buffer
    mzss_pkg::t_size ram_rdata;
    mzss_pkg::t_size here;

    mzss_ram #(
        .WIDTH (mzss_pkg::SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.col),
        .i_wdata (here),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // compute stage
    mzss_pkg::t_size r_left;
    mzss_pkg::t_size r_diag;
    mzss_pkg::t_size r_fwd_data;
    mzss_pkg::t_size r_best;
    mzss_pkg::t_size up;
    mzss_pkg::t_size left;
    mzss_pkg::t_size diag;
    mzss_pkg::t_size low;
    mzss_pkg::t_size n_best;
    mzss_pkg::t_result res;

    always_comb begin
        up   = r_s1.top ? '0 : (r_s1.fwd ? r_fwd_data : ram_rdata);
        left = r_s1.first ? '0 : r_left;
        diag = (r_s1.first || r_s1.top) ? '0 : r_diag;
        low  = (up < left) ? up : left;
        low  = (diag < low) ? diag : low;
        here = r_s1.blocked ? '0 : low + mzss_pkg::SIZE_W'(1);
        n_best = (here > r_best) ? here : r_best;
        res.square_here = here;
        res.largest     = n_best;
        res.frame_done  = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (r_s1_valid) begin
            r_best <= r_s1.last ? '0 : n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_left     <= here;
            r_diag     <= up;
            r_fwd_data <= here;
        end
    end

    // output queue
    mzss_pkg::t_result r_fifo [mzss_pkg::FIFO_DEPTH];
    mzss_pkg::t_fptr   r_wptr;
    mzss_pkg::t_fptr   r_rptr;
    logic              pop;

    assign o_valid = (r_occ != '0);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_occ  <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wptr <= (r_wptr == mzss_pkg::FPTR_W'(mzss_pkg::FIFO_DEPTH - 1)) ?
                          '0 : r_wptr + mzss_pkg::FPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == mzss_pkg::FPTR_W'(mzss_pkg::FIFO_DEPTH - 1)) ?
                          '0 : r_rptr + mzss_pkg::FPTR_W'(1);
            end
            if (r_s1_valid && !pop) begin
                r_occ <= r_occ + mzss_pkg::FPTR_W'(1);
            end else if (!r_s1_valid && pop) begin
                r_occ <= r_occ - mzss_pkg::FPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wptr] <= res;
        end
    end

    assign o_square_here = r_fifo[r_rptr].square_here;
    assign o_largest     = r_fifo[r_rptr].largest;
    assign o_frame_done  = r_fifo[r_rptr].frame_done;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_occ < mzss_pkg::FPTR_W'(mzss_pkg::FIFO_DEPTH)))
        else $error("output queue overflow");

    a_bypass_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.fwd) |-> ($past(r_s1_valid) && ($past(r_s1.col) == r_s1.col)))
        else $error("bypass taken without a matching write");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last_col && last_row) |=> ((r_col == '0) && (r_row == '0)))
        else $error("counters not cleared after last cell");

    a_largest_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_largest >= o_square_here))
        else $error("running maximum below current size");
`endif

endmodule

[verif/max_zero_square_scan_tb.sv]
module max_zero_square_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 1024;
    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_CELLS = 420;
    localparam int QUIET_CELLS  = 100;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ZERO_MIX [4] = '{50, 80, 95, 100};

    typedef enum logic {
        STEP_CELL,
        STEP_WRITE
    } t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        mzss_pkg::t_cfg_reg  target;
        mzss_pkg::t_cfg_data value;
        logic                blocked;
        logic                typed;
        mzss_pkg::t_result   result;
    } t_directed_step;

    // Walks from the reset size into shrinks, zero counts, a 1x1 matrix,
    // a small full matrix and oversized counts cut back mid-matrix.
    localparam t_directed_step DIRECTED_PLAN [31] = '{
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b1, '{11'd1, 11'd1, 1'b0}},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b1, 1'b1, '{11'd0, 11'd1, 1'b0}},
        '{STEP_WRITE, mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_ROW_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b1, '{11'd1, 11'd1, 1'b1}},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b1, 1'b1, '{11'd0, 11'd0, 1'b1}},
        '{STEP_WRITE, mzss_pkg::CFG_COL_COUNT, 11'd3,    1'b0, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_ROW_COUNT, 11'd2,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_COL_COUNT, 11'd2047, 1'b0, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_ROW_COUNT, 11'd2047, 1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b1, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_COL_COUNT, 11'd3,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_WRITE, mzss_pkg::CFG_ROW_COUNT, 11'd1,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0},
        '{STEP_CELL,  mzss_pkg::CFG_COL_COUNT, 11'd0,    1'b0, 1'b0, '0}
    };

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [mzss_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    mzss_pkg::t_cfg_data            i_cfg_data = '0;
    logic                           i_valid    = 1'b0;
    logic                           i_cell_req = 1'b0;
    logic                           i_ready    = 1'b1;
    logic                           o_ready;
    logic                           o_valid;
    mzss_pkg::t_size                o_square_here;
    mzss_pkg::t_size                o_largest;
    logic                           o_frame_done;

    // scan state mirrored from the block
    mzss_pkg::t_size     row_above [MAX_DIM];
    mzss_pkg::t_size     left_side     = '0;
    mzss_pkg::t_size     upper_left    = '0;
    mzss_pkg::t_size     best_side     = '0;
    int unsigned         col_pos       = 0;
    int unsigned         row_pos       = 0;
    mzss_pkg::t_cfg_data col_cfg       = mzss_pkg::t_cfg_data'(MAX_DIM);
    mzss_pkg::t_cfg_data row_cfg       = mzss_pkg::t_cfg_data'(MAX_DIM);
    int unsigned         written_cols  = 0;

    mzss_pkg::t_result   pending_results [$];
    mzss_pkg::t_result   head_result;
    int                  mismatches    = 0;
    int                  stall_pct     = 0;
    int                  zero_pct      = 80;
    int                  ready_hold    = 0;
    logic                quiet         = 1'b0;

    max_zero_square_scan #(
        .MAX_COLS (MAX_DIM),
        .MAX_ROWS (MAX_DIM)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cell_req    (i_cell_req),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_square_here (o_square_here),
        .o_largest     (o_largest),
        .o_frame_done  (o_frame_done)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned eff_count(input mzss_pkg::t_cfg_data v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic mzss_pkg::t_result scan_cell(input logic blocked);
        int unsigned       cols;
        int unsigned       rows;
        int unsigned       c;
        mzss_pkg::t_size   up;
        mzss_pkg::t_size   lf;
        mzss_pkg::t_size   dg;
        mzss_pkg::t_size   least;
        mzss_pkg::t_size   here;
        logic              last_col;
        logic              last_row;
        mzss_pkg::t_result r;
        cols = eff_count(col_cfg);
        rows = eff_count(row_cfg);
        c    = col_pos % MAX_DIM;
        up   = (row_pos == 0) ? '0 : row_above[c];
        lf   = (c == 0) ? '0 : left_side;
        dg   = (c == 0 || row_pos == 0) ? '0 : upper_left;
        least = up;
        if (lf < least) least = lf;
        if (dg < least) least = dg;
        here = blocked ? '0 : mzss_pkg::t_size'(least + 1);
        if (here > best_side) best_side = here;
        upper_left   = up;
        left_side    = here;
        row_above[c] = here;
        if (c + 1 > written_cols) written_cols = c + 1;
        last_col = (c + 1 >= cols);
        last_row = (row_pos + 1 >= rows);
        r.square_here = here;
        r.largest     = best_side;
        r.frame_done  = last_col && last_row;
        if (last_col && last_row) begin
            col_pos    = 0;
            row_pos    = 0;
            best_side  = '0;
            left_side  = '0;
            upper_left = '0;
        end else if (last_col) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
        return r;
    endfunction

    // a position past a shrunk count is the last one of its row or column
    function automatic int unsigned cells_left_in_frame();
        int unsigned cols;
        int unsigned rows;
        int unsigned c;
        int unsigned in_row;
        int unsigned rows_after;
        cols       = eff_count(col_cfg);
        rows       = eff_count(row_cfg);
        c          = col_pos % MAX_DIM;
        in_row     = (c + 1 >= cols) ? 1 : cols - c;
        rows_after = (row_pos + 1 >= rows) ? 0 : rows - 1 - row_pos;
        return in_row + rows_after * cols;
    endfunction

    function automatic mzss_pkg::t_cfg_data pick_dim();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return mzss_pkg::t_cfg_data'($urandom_range(13, 24));
            end
            default: begin
                return mzss_pkg::t_cfg_data'($urandom_range(1, 12));
            end
        endcase
    endfunction

    function automatic mzss_pkg::t_cfg_data pick_oversize();
        if ($urandom_range(0, 1)) return mzss_pkg::t_cfg_data'(MAX_DIM);
        return mzss_pkg::t_cfg_data'($urandom_range(MAX_DIM + 1, 2047));
    endfunction

    task automatic send_cell(input logic blocked, input logic typed,
                             input mzss_pkg::t_result typed_result);
        mzss_pkg::t_result predicted;
        int                gap;
        if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cell_req <= blocked;
        do @(posedge i_clk); while (!o_ready);
        predicted = scan_cell(blocked);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge i_clk);
    endtask

    task automatic send_cells(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_cell(($urandom_range(0, 99) < zero_pct) ? 1'b0 : 1'b1, 1'b0, '0);
        end
    endtask

    task automatic await_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_count(input mzss_pkg::t_cfg_reg target,
                               input mzss_pkg::t_cfg_data value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= target;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (target == mzss_pkg::CFG_COL_COUNT) col_cfg = value;
        else row_cfg = value;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            ready_hold = $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with no item pending: here=%0d largest=%0d done=%0b",
                             $realtime, o_square_here, o_largest, o_frame_done);
                mismatches++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_square_here !== head_result.square_here ||
                    o_largest !== head_result.largest ||
                    o_frame_done !== head_result.frame_done) begin
                    if (mismatches < 10)
                        $display({"%0t: mismatch: expected here=%0d largest=%0d done=%0b,",
                                  " got here=%0d largest=%0d done=%0b"},
                                 $realtime, head_result.square_here, head_result.largest,
                                 head_result.frame_done, o_square_here, o_largest,
                                 o_frame_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("** max_zero_square_scan: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int                  phase;
        int                  random_cells;
        int unsigned         n;
        mzss_pkg::t_cfg_data new_dim;
        phase        = 0;
        random_cells = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_PLAN[k]) begin
            if (DIRECTED_PLAN[k].kind == STEP_WRITE) begin
                await_drain();
                write_count(DIRECTED_PLAN[k].target, DIRECTED_PLAN[k].value);
            end else begin
                send_cell(DIRECTED_PLAN[k].blocked, DIRECTED_PLAN[k].typed,
                          DIRECTED_PLAN[k].result);
            end
        end

        while (phase < 8 || random_cells + QUIET_CELLS < RANDOM_CELLS) begin
            await_drain();
            stall_pct = 20 * $urandom_range(0, 2);
            zero_pct  = ZERO_MIX[$urandom_range(0, 3)];
            if (phase == 3 || phase == 6) begin
                // full-width row cut short, then a full-height column cut short
                if (col_pos != 0 || row_pos != 0) begin
                    send_cells(cells_left_in_frame());
                    await_drain();
                end
                if (phase == 3) begin
                    write_count(mzss_pkg::CFG_COL_COUNT, pick_oversize());
                    write_count(mzss_pkg::CFG_ROW_COUNT, mzss_pkg::t_cfg_data'(2));
                end else begin
                    write_count(mzss_pkg::CFG_COL_COUNT,
                                mzss_pkg::t_cfg_data'($urandom_range(0, 1)));
                    write_count(mzss_pkg::CFG_ROW_COUNT, pick_oversize());
                end
                send_cells($urandom_range(80, 120));
                await_drain();
                if (phase == 3) write_count(mzss_pkg::CFG_COL_COUNT, pick_dim());
                else write_count(mzss_pkg::CFG_ROW_COUNT, pick_dim());
                send_cells(cells_left_in_frame());
            end else begin
                if (col_pos == 0 && row_pos == 0) begin
                    write_count(mzss_pkg::CFG_COL_COUNT, pick_dim());
                    write_count(mzss_pkg::CFG_ROW_COUNT, pick_dim());
                end else if ($urandom_range(0, 2) == 0) begin
                    new_dim = pick_dim();
                    // widening past row 0 must not reach row memory never written
                    if ($urandom_range(0, 1))
                        write_count(mzss_pkg::CFG_ROW_COUNT, new_dim);
                    else if (row_pos == 0 || eff_count(new_dim) <= written_cols)
                        write_count(mzss_pkg::CFG_COL_COUNT, new_dim);
                end
                n = cells_left_in_frame();
                if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
                send_cells(n);
                random_cells += n;
            end
            phase++;
        end

        // closing stretch at full rate on both sides
        await_drain();
        quiet     = 1'b1;
        stall_pct = 0;
        zero_pct  = ZERO_MIX[$urandom_range(0, 3)];
        send_cells(QUIET_CELLS);

        await_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** max_zero_square_scan: PASSED **");
        else
            $display("** max_zero_square_scan: FAILED **");
        $finish;
    end

endmodule
